// ===== sv/gcfp_pkg.sv =====
// Shared types and constants for the gimbal command frame parser.
`default_nettype none
package gcfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_LEN   = 7;
    localparam int unsigned FRAME_W     = FRAME_LEN * BYTE_W;
    localparam int unsigned POS_W       = 3;

    localparam logic [BYTE_W-1:0] START_ALT     = 8'h81;
    localparam logic [BYTE_W-1:0] KIND_SUM      = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_TERM     = 8'h09;
    localparam logic [BYTE_W-1:0] END_MARK      = 8'hFF;
    localparam logic [BYTE_W-1:0] START_RESET   = 8'hFF;

    localparam logic [POS_W-1:0]  POS_BODY_FIRST = 3'd2;
    localparam logic [POS_W-1:0]  POS_SUM_CHECK  = 3'd6;
    localparam logic [POS_W-1:0]  POS_TERM_LAST  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_START    = 2'd1,
        PH_SUMBODY  = 2'd2,
        PH_TERMBODY = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_SUM_OK  = 2'd1,
        ST_TERM_OK = 2'd2,
        ST_BAD     = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [FRAME_W-1:0]   frame_bytes;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/gimbal_command_frame_parser.sv =====
// Gimbal command frame parser top level: byte input register, parser, result register.
//
// Input channel: one received byte per beat on i_rx_byte (i_valid / o_ready).
// Output channel: one result per input beat on o_status and o_frame_bytes
// (o_valid / i_ready). o_frame_bytes holds frame bytes 0..6, byte 0 in bits
// 7..0, and is zero while o_status reports an incomplete frame.
// Configuration channel: i_cfg_valid / o_cfg_ready carries the primary start
// byte on i_cfg_start_byte; 0x81 is always taken as a start byte too. Write it
// only while no byte is in flight.
// Path: an accepted byte is held in the input register, then passes through the
// parser into the result register, from which the receiver takes it.
// Throughput: one byte per cycle unless the output stalls; the parser state
// updates as a byte moves from the input register to the result register.
// Reset: synchronous, active low; the parser goes idle, the frame store and
// checksum clear, the start byte returns to 0xFF and both registers empty.
// Stall: while i_ready is low the result holds; one more byte is taken into
// the input register, then o_ready drops until the result is taken.
`default_nettype none
module gimbal_command_frame_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output wire logic                          o_cfg_ready,
    input  wire logic [gcfp_pkg::BYTE_W-1:0]   i_cfg_start_byte,
    input  wire logic                          i_valid,
    output wire logic                          o_ready,
    input  wire logic [gcfp_pkg::BYTE_W-1:0]   i_rx_byte,
    output wire logic                          o_valid,
    input  wire logic                          i_ready,
    output wire logic [1:0]                    o_status,
    output wire logic [gcfp_pkg::FRAME_W-1:0]  o_frame_bytes
);
    import gcfp_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           parse_result;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    gcfp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_start_byte),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .o_result     (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
        end else if (i_cfg_valid) begin
            r_start_byte <= i_cfg_start_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= parse_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_frame_bytes = r_out.frame_bytes;

endmodule
`default_nettype wire

// ===== sv/gcfp_parse.sv =====
// Frame parse state and per-byte result logic.
`default_nettype none
module gcfp_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [gcfp_pkg::BYTE_W-1:0]   i_start_byte,
    input  wire logic                          i_step,
    input  wire logic [gcfp_pkg::BYTE_W-1:0]   i_byte,
    output gcfp_pkg::t_result                  o_result
);
    import gcfp_pkg::*;

    t_phase                          r_phase, n_phase;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic [BYTE_W-1:0]               r_sum, n_sum;
    logic [FRAME_LEN-1:0][BYTE_W-1:0] r_store, n_store;
    t_status                         n_status;
    logic [POS_W-1:0]                term_pos;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_store  = r_store;
        n_status = ST_NONE;
        term_pos = (r_pos > POS_TERM_LAST) ? POS_TERM_LAST : r_pos;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == i_start_byte || i_byte == START_ALT) begin
                    n_store    = '0;
                    n_store[0] = i_byte;
                    n_sum      = '0;
                    n_phase    = PH_START;
                end
            end
            PH_START: begin
                if (i_byte == KIND_SUM) begin
                    n_store[1] = i_byte;
                    n_sum      = r_sum + i_byte;
                    n_pos      = POS_BODY_FIRST;
                    n_phase    = PH_SUMBODY;
                end else if (i_byte == KIND_TERM) begin
                    n_store[1] = i_byte;
                    n_pos      = POS_BODY_FIRST;
                    n_phase    = PH_TERMBODY;
                end else begin
                    n_sum   = '0;
                    n_phase = PH_IDLE;
                end
            end
            PH_SUMBODY: begin
                if (r_pos >= POS_SUM_CHECK) begin
                    n_store[FRAME_LEN-1] = i_byte;
                    n_pos    = POS_BODY_FIRST;
                    n_phase  = PH_IDLE;
                    n_status = (r_sum == i_byte) ? ST_SUM_OK : ST_BAD;
                end else begin
                    for (int i = 0; i < FRAME_LEN; i++) begin
                        if (r_pos == POS_W'(i)) begin
                            n_store[i] = i_byte;
                        end
                    end
                    n_pos = r_pos + 1'b1;
                    n_sum = r_sum + i_byte;
                end
            end
            PH_TERMBODY: begin
                for (int i = 0; i < FRAME_LEN; i++) begin
                    if (term_pos == POS_W'(i)) begin
                        n_store[i] = i_byte;
                    end
                end
                if (term_pos == POS_TERM_LAST) begin
                    n_pos    = POS_BODY_FIRST;
                    n_phase  = PH_IDLE;
                    n_status = (i_byte == END_MARK) ? ST_TERM_OK : ST_BAD;
                end else begin
                    n_pos = term_pos + 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.status      = n_status;
        o_result.frame_bytes = (n_status != ST_NONE) ? n_store : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= POS_BODY_FIRST;
            r_sum   <= '0;
            r_store <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_store <= n_store;
        end
    end

endmodule
`default_nettype wire
